>>> rtl/core/radix_integer_to_ascii_defines.svh
// assertion macros for the radix integer to ascii block
// no dependencies; included by the top level
`ifndef RADIX_INTEGER_TO_ASCII_DEFINES_SVH
`define RADIX_INTEGER_TO_ASCII_DEFINES_SVH

`ifndef SYNTHESIS
`define RITOA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ritoa check failed");
`define RITOA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ritoa check failed");
`else
`define RITOA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RITOA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/ritoa_pkg.sv
// shared types, constants and helpers for the radix integer to ascii block
// no dependencies
package ritoa_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int MAX_DIGITS_DEF  = 64;

    localparam int VALUE_PORT_W = 64;
    localparam int DIGIT_W      = 6;
    localparam int CHAR_W       = 7;
    localparam int COUNT_W      = 7;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 2'd1;

    localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [DIGIT_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd10;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_A    = 7'd65;
    localparam logic [DIGIT_W-1:0] DEC_TEN   = 6'd10;

    typedef struct packed {
        logic               step;   // a digit finished this cycle
        logic [DIGIT_W-1:0] digit;
        logic               more;   // quotient nonzero, another digit follows
    } t_div_status;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] res;
        if (d < DEC_TEN) begin
            res = {1'b0, d} + ASCII_ZERO;
        end else begin
            res = {1'b0, d} - {1'b0, DEC_TEN} + ASCII_A;
        end
        return res;
    endfunction

endpackage

>>> rtl/core/ritoa_ram.sv
// generic single write port memory with registered read
// no dependencies
module ritoa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/ritoa_div.sv
// bit-serial restoring divider: peels off one digit per pass over all VALUE_WIDTH quotient bits
// depends on ritoa_pkg
module ritoa_div #(
    parameter int VALUE_WIDTH = ritoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [VALUE_WIDTH-1:0]           i_value,
    input  logic [ritoa_pkg::DIGIT_W-1:0]    i_radix,
    output ritoa_pkg::t_div_status           o_status
);

    localparam int BW = $clog2(VALUE_WIDTH);
    localparam int DW = ritoa_pkg::DIGIT_W;

    logic                   r_run, n_run;
    logic [VALUE_WIDTH-1:0] r_quo, n_quo;
    logic [DW-1:0]          r_rem, n_rem;
    logic                   r_nz, n_nz;
    logic [BW-1:0]          r_bitcnt, n_bitcnt;

    logic [DW:0]   w_trial;
    logic          w_ge;
    logic [DW-1:0] w_rem;
    logic [DW:0]   w_diff;
    logic          w_last;

    always_comb begin
        w_trial = {r_rem, r_quo[VALUE_WIDTH-1]};
        w_diff  = w_trial - {1'b0, i_radix};
        w_ge    = (w_trial >= {1'b0, i_radix});
        w_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        w_last  = (r_bitcnt == BW'(VALUE_WIDTH - 1));
    end

    assign o_status.step  = r_run && w_last;
    assign o_status.digit = w_rem;
    assign o_status.more  = r_nz | w_ge;

    always_comb begin
        n_run    = r_run;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_nz     = r_nz;
        n_bitcnt = r_bitcnt;
        if (i_start) begin
            n_run    = 1'b1;
            n_quo    = i_value;
            n_rem    = '0;
            n_nz     = 1'b0;
            n_bitcnt = '0;
        end else if (r_run) begin
            n_quo = {r_quo[VALUE_WIDTH-2:0], w_ge};
            if (w_last) begin
                // quotient is complete, restart on it if nonzero
                n_run    = r_nz | w_ge;
                n_rem    = '0;
                n_nz     = 1'b0;
                n_bitcnt = '0;
            end else begin
                n_rem    = w_rem;
                n_nz     = r_nz | w_ge;
                n_bitcnt = r_bitcnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_bitcnt <= '0;
        end else begin
            r_run    <= n_run;
            r_bitcnt <= n_bitcnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_nz  <= n_nz;
    end

endmodule

>>> rtl/core/radix_integer_to_ascii.sv
// top level: radix integer to ascii converter with config registers and output stage
// depends on ritoa_pkg, ritoa_div, ritoa_ram and radix_integer_to_ascii_defines.svh
//
//  channel  direction  handshake                payload
//  input    in         i_valid / o_stall        i_value
//  output   out        o_valid / i_stall        o_digit_char, o_char_count, o_last
//  config   in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// per item, the bit-serial divider makes one quotient bit per cycle and peels off one digit
// per pass; each character then passes a memory read state and a load state, and the load
// waits while the output is stalled
// reset (i_rst_n low, synchronous) sets radix 10, minimum length 0 and empties the output
// a stalled output holds its character; the next item is taken once the last one is loaded
`include "radix_integer_to_ascii_defines.svh"

module radix_integer_to_ascii #(
    parameter int MAX_DIGITS  = ritoa_pkg::MAX_DIGITS_DEF,
    parameter int VALUE_WIDTH = ritoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [ritoa_pkg::VALUE_PORT_W-1:0]  i_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [ritoa_pkg::CHAR_W-1:0]        o_digit_char,
    output logic [ritoa_pkg::COUNT_W-1:0]       o_char_count,
    output logic                                o_last,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ritoa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ritoa_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int AW = $clog2(MAX_DIGITS);
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int DW = ritoa_pkg::DIGIT_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_READ = 4'b0100,
        ST_LOAD = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [DW-1:0] r_radix, n_radix;
    logic [CW-1:0] r_min, n_min;
    logic [CW-1:0] r_ndig, n_ndig;
    logic [CW-1:0] r_total, n_total;
    logic [AW-1:0] r_idx, n_idx;

    logic                             r_out_valid, n_out_valid;
    logic [ritoa_pkg::CHAR_W-1:0]     r_char, n_char;
    logic [ritoa_pkg::COUNT_W-1:0]    r_count, n_count;
    logic                             r_last, n_last;

    ritoa_pkg::t_div_status w_div;
    logic                   w_start;
    logic                   w_we;
    logic [DW-1:0]          w_rdata;
    logic [DW-1:0]          w_digit;
    logic [CW-1:0]          w_ndig_inc;
    logic [CW-1:0]          w_total;
    logic [CW-1:0]          w_total_m1;
    logic                   w_room;
    logic                   w_load;
    logic [DW-1:0]          w_cfg_r;
    logic [CW-1:0]          w_cfg_m;

    assign o_stall     = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_start     = (r_state == ST_IDLE) && i_valid;
    assign w_room      = (r_ndig < CW'(MAX_DIGITS));
    assign w_we        = (r_state == ST_DIV) && w_div.step && w_room;

    ritoa_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_value  (i_value[VALUE_WIDTH-1:0]),
        .i_radix  (r_radix),
        .o_status (w_div)
    );

    ritoa_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_DIGITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_ndig[AW-1:0]),
        .i_wdata (w_div.digit),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // config writes, clamped into range; the radix is first cut to the low DIGIT_W data bits
    always_comb begin
        n_radix = r_radix;
        n_min   = r_min;
        w_cfg_r = i_cfg_data[DW-1:0];
        if (w_cfg_r < ritoa_pkg::RADIX_MIN) begin
            w_cfg_r = ritoa_pkg::RADIX_MIN;
        end else if (w_cfg_r > ritoa_pkg::RADIX_MAX) begin
            w_cfg_r = ritoa_pkg::RADIX_MAX;
        end
        if (i_cfg_data > ritoa_pkg::CFG_DATA_W'(MAX_DIGITS)) begin
            w_cfg_m = CW'(MAX_DIGITS);
        end else begin
            w_cfg_m = i_cfg_data[CW-1:0];
        end
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ritoa_pkg::CFG_RADIX:   n_radix = w_cfg_r;
                ritoa_pkg::CFG_MIN_LEN: n_min   = w_cfg_m;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_ndig_inc = r_ndig + CW'(w_room);
        w_total    = (w_ndig_inc > r_min) ? w_ndig_inc : r_min;
        w_total_m1 = w_total - 1'b1;
        // positions above the real digits are padding zeros
        w_digit    = (CW'(r_idx) >= r_ndig) ? '0 : w_rdata;
        w_load     = (r_state == ST_LOAD) && (!r_out_valid || !i_stall);
    end

    always_comb begin
        n_state     = r_state;
        n_ndig      = r_ndig;
        n_total     = r_total;
        n_idx       = r_idx;
        n_char      = r_char;
        n_count     = r_count;
        n_last      = r_last;
        n_out_valid = r_out_valid && i_stall;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_ndig  = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div.step) begin
                    n_ndig = w_ndig_inc;
                    if (!w_div.more) begin
                        n_total = w_total;
                        n_idx   = w_total_m1[AW-1:0];
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_char      = ritoa_pkg::digit_to_ascii(w_digit);
                    n_count     = ritoa_pkg::COUNT_W'(r_total);
                    n_last      = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = ST_READ;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_radix     <= ritoa_pkg::RADIX_RESET;
            r_min       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_radix     <= n_radix;
            r_min       <= n_min;
        end
        r_ndig  <= n_ndig;
        r_total <= n_total;
        r_idx   <= n_idx;
        r_char  <= n_char;
        r_count <= n_count;
        r_last  <= n_last;
    end

    assign o_valid      = r_out_valid;
    assign o_digit_char = r_char;
    assign o_char_count = r_count;
    assign o_last       = r_last;

    `RITOA_ASSERT_NXT(a_take_starts_div, i_clk, i_rst_n, i_valid && !o_stall, r_state == ST_DIV)
    `RITOA_ASSERT_IMP(a_mid_run_busy, i_clk, i_rst_n, o_valid && !o_last, r_state != ST_IDLE)
    `RITOA_ASSERT_IMP(a_idx_in_total, i_clk, i_rst_n, r_state == ST_LOAD, CW'(r_idx) < r_total)
    `RITOA_ASSERT_IMP(a_radix_range, i_clk, i_rst_n, 1'b1, r_radix >= ritoa_pkg::RADIX_MIN && r_radix <= ritoa_pkg::RADIX_MAX)

endmodule
